// ===== design/playfair_digraph_cipher_macros.svh =====
// assertion helpers used by the checker file
`ifndef PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define PFC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("playfair check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define PFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("playfair check failed");

`endif

// ===== design/pfc_pkg.sv =====
package pfc_pkg;

  localparam int SquareSide = 5;
  localparam int CellCount  = SquareSide * SquareSide;
  localparam int Alphabet   = 26;
  localparam int LetterW    = 5;
  localparam int PosW       = 3;
  localparam int CellAddrW  = $clog2(CellCount);

  localparam logic [LetterW-1:0] LetterI = LetterW'(8);
  localparam logic [LetterW-1:0] LetterJ = LetterW'(9);
  localparam logic [LetterW-1:0] LetterZ = LetterW'(25);

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_KEY    = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_PAIR   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_ABSENT    = 2'd1,
    STATUS_NOT_READY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_POS_B,
    ST_CALC,
    ST_CELL_B,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [LetterW-1:0] first_letter;
    logic [LetterW-1:0] second_letter;
    logic               pad_second;
  } item_t;

  typedef struct packed {
    logic [LetterW-1:0] out_first;
    logic [LetterW-1:0] out_second;
    logic [1:0]         status;
  } result_t;

  typedef struct packed {
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
  } pos_t;

  typedef struct packed {
    logic busy;
    logic fill;
    logic ld_pos_a;
    logic calc;
    logic ld_first;
    logic emit;
  } seq_ctrl_t;

  function automatic logic [PosW-1:0] shift_idx(logic [PosW-1:0] v, logic dir);
    logic [PosW-1:0] r;
    if (dir) begin
      r = (v == '0) ? PosW'(SquareSide - 1) : v - PosW'(1);
    end else begin
      r = (v == PosW'(SquareSide - 1)) ? '0 : v + PosW'(1);
    end
    return r;
  endfunction

  function automatic logic [CellAddrW-1:0] cell_addr(logic [PosW-1:0] row,
                                                     logic [PosW-1:0] col);
    return CellAddrW'(row) * CellAddrW'(SquareSide) + CellAddrW'(col);
  endfunction

endpackage

// ===== design/pfc_ram.sv =====
module pfc_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/pfc_rule.sv =====
module pfc_rule (
  input  pfc_pkg::pos_t                     pos_a_i,
  input  pfc_pkg::pos_t                     pos_b_i,
  input  logic                              dir_i,
  output logic [pfc_pkg::CellAddrW-1:0]     addr_a_o,
  output logic [pfc_pkg::CellAddrW-1:0]     addr_b_o
);
  import pfc_pkg::*;

  always_comb begin
    if (pos_a_i.row == pos_b_i.row) begin
      addr_a_o = cell_addr(pos_a_i.row, shift_idx(pos_a_i.col, dir_i));
      addr_b_o = cell_addr(pos_b_i.row, shift_idx(pos_b_i.col, dir_i));
    end else if (pos_a_i.col == pos_b_i.col) begin
      addr_a_o = cell_addr(shift_idx(pos_a_i.row, dir_i), pos_a_i.col);
      addr_b_o = cell_addr(shift_idx(pos_b_i.row, dir_i), pos_b_i.col);
    end else begin
      // rectangle: swap columns
      addr_a_o = cell_addr(pos_a_i.row, pos_b_i.col);
      addr_b_o = cell_addr(pos_b_i.row, pos_a_i.col);
    end
  end

endmodule

// ===== design/pfc_seq.sv =====
module pfc_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  pfc_pkg::kind_e     kind_i,
  input  logic               pair_ok_i,
  input  logic               fill_last_i,
  output pfc_pkg::seq_ctrl_t ctrl_o
);
  import pfc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept_i && kind_i == KIND_FINISH) begin
          state_d = ST_FILL;
        end else if (accept_i && kind_i == KIND_PAIR && pair_ok_i) begin
          state_d = ST_POS_B;
        end
      end
      ST_FILL: begin
        if (fill_last_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_POS_B:  state_d = ST_CALC;
      ST_CALC:   state_d = ST_CELL_B;
      ST_CELL_B: state_d = ST_EMIT;
      ST_EMIT:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    unique case (state_q)
      ST_IDLE:   ctrl_o.busy = 1'b0;
      ST_FILL: begin
        ctrl_o.busy = 1'b1;
        ctrl_o.fill = 1'b1;
      end
      ST_POS_B: begin
        ctrl_o.busy     = 1'b1;
        ctrl_o.ld_pos_a = 1'b1;
      end
      ST_CALC: begin
        ctrl_o.busy = 1'b1;
        ctrl_o.calc = 1'b1;
      end
      ST_CELL_B: begin
        ctrl_o.busy     = 1'b1;
        ctrl_o.ld_first = 1'b1;
      end
      ST_EMIT: begin
        ctrl_o.busy = 1'b1;
        ctrl_o.emit = 1'b1;
      end
      default:   ctrl_o = '0;
    endcase
  end

endmodule

// ===== design/playfair_digraph_cipher.sv =====
// channel   direction  handshake                      payload
// command   in         start, busy                    item_i
// result    out        result_strobe_o (no backpress) result_o
// config    in         cfg_valid_i, cfg_ready_o       cfg_data_i (direction)
//
// clear and key letter never make the block busy; finish walks the alphabet while busy
// a pair is busy through POS_B, CALC, CELL_B and EMIT: two reads of the position
// ram, then two reads of the square ram through its single read port; its result
// strobes in the cycle after the last busy one
// a pair rejected for status shows its result the cycle after it is taken
// reset clears the placed flags, fill count, ready flag and direction;
// the two rams need no clearing pass
module playfair_digraph_cipher (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  pfc_pkg::item_t   item_i,
  output logic             result_strobe_o,
  output pfc_pkg::result_t result_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_data_i
);
  import pfc_pkg::*;

  seq_ctrl_t ctrl;
  logic      accept;

  logic [Alphabet-1:0]  placed_q, placed_d;
  logic [LetterW-1:0]   fill_cnt_q, fill_cnt_d;
  pos_t                 fill_pos_q, fill_pos_d;
  logic                 ready_q, ready_d;
  logic                 dir_q;
  logic [LetterW-1:0]   letter_cnt_q, letter_cnt_d;
  logic [LetterW-1:0]   b_q;
  pos_t                 pos_a_q;
  logic [CellAddrW-1:0] addr_b_q;
  logic [LetterW-1:0]   first_q;
  result_t              result_q, result_d;
  logic                 strobe_q, strobe_d;

  logic [LetterW-1:0]   b_letter;
  logic                 pair_ok;
  logic                 fill_last;
  logic [LetterW-1:0]   place_letter;
  logic                 place_skip;
  logic                 place_req;
  logic                 place_ok;

  logic [LetterW-1:0]   pos_raddr;
  logic [2*PosW-1:0]    pos_rdata;
  logic [CellAddrW-1:0] cell_raddr;
  logic [LetterW-1:0]   cell_rdata;
  logic [CellAddrW-1:0] addr_a, addr_b;

  function automatic logic is_placed(logic [Alphabet-1:0] v, logic [LetterW-1:0] l);
    return (l < LetterW'(Alphabet)) && v[l];
  endfunction

  assign accept      = start && !ctrl.busy;
  assign busy        = ctrl.busy;
  assign cfg_ready_o = !ctrl.busy;

  assign b_letter  = item_i.pad_second ? LetterZ : item_i.second_letter;
  assign pair_ok   = ready_q && is_placed(placed_q, item_i.first_letter)
                     && is_placed(placed_q, b_letter);
  assign fill_last = letter_cnt_q == LetterW'(Alphabet - 1);

  // placement unit shared by key letters and the finish walk
  assign place_letter = ctrl.fill ? letter_cnt_q : item_i.first_letter;
  assign place_skip   = (letter_cnt_q == LetterJ && !placed_q[LetterJ])
                     || (letter_cnt_q == LetterI && placed_q[LetterJ]);
  assign place_req    = ctrl.fill ? !place_skip
                      : (accept && item_i.kind == KIND_KEY && !ready_q);
  assign place_ok     = place_req && fill_cnt_q != LetterW'(CellCount)
                        && place_letter < LetterW'(Alphabet)
                        && !placed_q[place_letter];

  pfc_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .kind_i      (kind_e'(item_i.kind)),
    .pair_ok_i   (pair_ok),
    .fill_last_i (fill_last),
    .ctrl_o      (ctrl)
  );

  assign pos_raddr = ctrl.ld_pos_a ? b_q : item_i.first_letter;

  pfc_ram #(
    .Width (2 * PosW),
    .Depth (Alphabet)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (place_ok),
    .waddr_i (place_letter),
    .wdata_i (fill_pos_q),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  pfc_rule u_rule (
    .pos_a_i  (pos_a_q),
    .pos_b_i  (pos_t'(pos_rdata)),
    .dir_i    (dir_q),
    .addr_a_o (addr_a),
    .addr_b_o (addr_b)
  );

  assign cell_raddr = ctrl.ld_first ? addr_b_q : addr_a;

  pfc_ram #(
    .Width (LetterW),
    .Depth (CellCount)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (place_ok),
    .waddr_i (cell_addr(fill_pos_q.row, fill_pos_q.col)),
    .wdata_i (place_letter),
    .raddr_i (cell_raddr),
    .rdata_o (cell_rdata)
  );

  always_comb begin
    placed_d     = placed_q;
    fill_cnt_d   = fill_cnt_q;
    fill_pos_d   = fill_pos_q;
    ready_d      = ready_q;
    letter_cnt_d = letter_cnt_q;
    if (accept && item_i.kind == KIND_CLEAR) begin
      placed_d   = '0;
      fill_cnt_d = '0;
      fill_pos_d = '0;
      ready_d    = 1'b0;
    end
    if (accept && item_i.kind == KIND_FINISH) begin
      letter_cnt_d = '0;
    end
    if (ctrl.fill) begin
      letter_cnt_d = letter_cnt_q + LetterW'(1);
      if (fill_last) begin
        ready_d = 1'b1;
      end
    end
    if (place_ok) begin
      placed_d[place_letter] = 1'b1;
      fill_cnt_d             = fill_cnt_q + LetterW'(1);
      if (fill_pos_q.col == PosW'(SquareSide - 1)) begin
        fill_pos_d.col = '0;
        fill_pos_d.row = fill_pos_q.row + PosW'(1);
      end else begin
        fill_pos_d.col = fill_pos_q.col + PosW'(1);
      end
    end
  end

  always_comb begin
    result_d = result_q;
    strobe_d = 1'b0;
    if (accept && item_i.kind == KIND_PAIR && !pair_ok) begin
      strobe_d            = 1'b1;
      result_d.out_first  = '0;
      result_d.out_second = '0;
      result_d.status     = ready_q ? STATUS_ABSENT : STATUS_NOT_READY;
    end else if (ctrl.emit) begin
      strobe_d            = 1'b1;
      result_d.out_first  = first_q;
      result_d.out_second = cell_rdata;
      result_d.status     = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      placed_q     <= '0;
      fill_cnt_q   <= '0;
      fill_pos_q   <= '0;
      ready_q      <= 1'b0;
      dir_q        <= 1'b0;
      letter_cnt_q <= '0;
      strobe_q     <= 1'b0;
    end else begin
      placed_q     <= placed_d;
      fill_cnt_q   <= fill_cnt_d;
      fill_pos_q   <= fill_pos_d;
      ready_q      <= ready_d;
      letter_cnt_q <= letter_cnt_d;
      strobe_q     <= strobe_d;
      if (cfg_valid_i && cfg_ready_o) begin
        dir_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    result_q <= result_d;
    if (accept) begin
      b_q <= b_letter;
    end
    if (ctrl.ld_pos_a) begin
      pos_a_q <= pos_t'(pos_rdata);
    end
    if (ctrl.calc) begin
      addr_b_q <= addr_b;
    end
    if (ctrl.ld_first) begin
      first_q <= cell_rdata;
    end
  end

  assign result_strobe_o = strobe_q;
  assign result_o        = result_q;

endmodule

// ===== design/pfc_checker.sv =====
`include "playfair_digraph_cipher_macros.svh"

module pfc_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input pfc_pkg::item_t   item_i,
  input logic             result_strobe_o,
  input pfc_pkg::result_t result_o,
  input logic             cfg_valid_i,
  input logic             cfg_ready_o
);
  import pfc_pkg::*;

  // a rejected pair carries zero letters
  `PFC_ASSERT_NOW(a_err_zero, result_strobe_o && result_o.status != STATUS_OK,
                  result_o.out_first == '0 && result_o.out_second == '0)

  // only a pair transaction produces a result
  `PFC_ASSERT_NEXT(a_no_result, start && !busy && item_i.kind != KIND_PAIR,
                   !result_strobe_o)

  // the finish walk holds the block busy
  `PFC_ASSERT_NEXT(a_finish_busy, start && !busy && item_i.kind == KIND_FINISH, busy)

  // config is refused while a transaction is in flight
  `PFC_ASSERT_NOW(a_cfg_idle, busy, !cfg_ready_o)

endmodule

bind playfair_digraph_cipher pfc_checker u_pfc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .item_i          (item_i),
  .result_strobe_o (result_strobe_o),
  .result_o        (result_o),
  .cfg_valid_i     (cfg_valid_i),
  .cfg_ready_o     (cfg_ready_o)
);
